>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the cost grid cell store RTL.
// Needs nothing else; files that assert take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the house clock clk_i and reset rst_ni.
`define ASSERT_STD(lbl, prop, msg) `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/cgcs_pkg.sv
// Package for the cost grid cell store: codes, cell word layout and
// controller/datapath command and status structs. Depends on nothing.
`default_nettype none

package cgcs_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 64;

  localparam int CNT_W      = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [7:0]            NO_INFO    = 8'hFF;
  localparam logic [CFG_DATA_W-1:0] GRID_RESET = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    OP_CLEAR_ALL   = 3'd0,
    OP_CLEAR_CELL  = 3'd1,
    OP_SET_PAYLOAD = 3'd2,
    OP_MAX_PAYLOAD = 3'd3,
    OP_SET_WEIGHTS = 3'd4,
    OP_READ        = 3'd5,
    OP_NEIGHBOR    = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    DIR_EAST  = 3'd0,
    DIR_NORTH = 3'd1,
    DIR_WEST  = 3'd2,
    DIR_SOUTH = 3'd3
  } dir_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_OOB     = 2'd1,
    STAT_BAD_DIR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_WIPE,
    S_EXEC
  } state_e;

  // One memory word per cell
  typedef struct packed {
    logic       present;
    logic       has_weights;
    logic [7:0] payload;
    logic [7:0] north;
    logic [7:0] east;
    logic [7:0] south;
    logic [7:0] west;
  } cell_word_t;

  typedef struct packed {
    logic accept;  // latch the input beat and start its cell read
    logic wipe;    // clear one cell at the sweep pointer and advance
    logic commit;  // write back the cell, update counts, load the result
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_clear_all;  // the offered beat is a clear-all
    logic sweep_last;    // sweep pointer sits on the last cell
  } dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/cgcs_item_if.sv
// Input channel of the cost grid cell store: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface cgcs_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [2:0] direction;
  logic [7:0] payload_value;
  logic [7:0] north_weight_in;
  logic [7:0] east_weight_in;
  logic [7:0] south_weight_in;
  logic [7:0] west_weight_in;

  modport source (
    output valid, operation, cell_x, cell_y, direction, payload_value,
           north_weight_in, east_weight_in, south_weight_in, west_weight_in,
    input  ready
  );

  modport sink (
    input  valid, operation, cell_x, cell_y, direction, payload_value,
           north_weight_in, east_weight_in, south_weight_in, west_weight_in,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/cgcs_result_if.sv
// Output channel of the cost grid cell store: valid/ready plus one result.
// Depends on nothing.
`default_nettype none

interface cgcs_result_if;
  logic              valid;
  logic              ready;
  logic [7:0]        payload_out;
  logic [7:0]        north_weight;
  logic [7:0]        east_weight;
  logic [7:0]        south_weight;
  logic [7:0]        west_weight;
  logic [7:0]        selected_weight;
  logic signed [7:0] neighbor_x;
  logic signed [7:0] neighbor_y;
  logic [1:0]        status;
  logic [12:0]       occupied_count;
  logic [12:0]       weight_count;

  modport source (
    output valid, payload_out, north_weight, east_weight, south_weight,
           west_weight, selected_weight, neighbor_x, neighbor_y, status,
           occupied_count, weight_count,
    input  ready
  );

  modport sink (
    input  valid, payload_out, north_weight, east_weight, south_weight,
           west_weight, selected_weight, neighbor_x, neighbor_y, status,
           occupied_count, weight_count,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/cgcs_ctrl.sv
// Controller of the cost grid cell store: sequences accept, execute and
// clearing sweeps. Depends on cgcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cgcs_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   item_valid_i,
  output logic                        item_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output cgcs_pkg::ctrl_cmd_t         cmd_o,
  input  wire cgcs_pkg::dp_status_t   stat_i
);

  cgcs_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  // Result register can take a new beat
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cgcs_pkg::S_INIT: begin
        if (stat_i.sweep_last) state_d = cgcs_pkg::S_IDLE;
      end
      cgcs_pkg::S_IDLE: begin
        if (item_valid_i) begin
          state_d = stat_i.in_clear_all ? cgcs_pkg::S_WIPE : cgcs_pkg::S_EXEC;
        end
      end
      cgcs_pkg::S_WIPE: begin
        if (stat_i.sweep_last) state_d = cgcs_pkg::S_EXEC;
      end
      cgcs_pkg::S_EXEC: begin
        if (slot_free) state_d = cgcs_pkg::S_IDLE;
      end
      default: state_d = cgcs_pkg::S_INIT;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o        = '0;
    item_ready_o = 1'b0;
    case (state_q)
      cgcs_pkg::S_INIT: cmd_o.wipe = 1'b1;
      cgcs_pkg::S_IDLE: begin
        item_ready_o = 1'b1;
        cmd_o.accept = item_valid_i;
      end
      cgcs_pkg::S_WIPE: cmd_o.wipe = 1'b1;
      cgcs_pkg::S_EXEC: cmd_o.commit = slot_free;
      default: cmd_o = '0;
    endcase
  end

  // Hold a result until the sink takes it
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cgcs_pkg::S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_STD(a_commit_to_idle, cmd_o.commit |=> (state_q == cgcs_pkg::S_IDLE), "commit did not return to idle")
  `ASSERT_STD(a_exec_holds, (state_q == cgcs_pkg::S_EXEC) && !cmd_o.commit |=> (state_q == cgcs_pkg::S_EXEC), "stalled item left execute")
  `ASSERT_STD(a_result_from_exec, $rose(out_valid_q) |-> $past(state_q == cgcs_pkg::S_EXEC), "result appeared outside execute")

endmodule

`default_nettype wire

>>> hw/rtl/cgcs_datapath.sv
// Datapath of the cost grid cell store: config registers, item register,
// cell memory, update logic, counts and result register.
// Depends on cgcs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module cgcs_datapath #(
  parameter int MAX_COLUMNS = cgcs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cgcs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cgcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cgcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic [2:0]                      operation_i,
  input  wire logic [5:0]                      cell_x_i,
  input  wire logic [5:0]                      cell_y_i,
  input  wire logic [2:0]                      direction_i,
  input  wire logic [7:0]                      payload_value_i,
  input  wire logic [7:0]                      north_weight_in_i,
  input  wire logic [7:0]                      east_weight_in_i,
  input  wire logic [7:0]                      south_weight_in_i,
  input  wire logic [7:0]                      west_weight_in_i,
  input  wire cgcs_pkg::ctrl_cmd_t             cmd_i,
  output cgcs_pkg::dp_status_t                 stat_o,
  output logic [7:0]                           payload_out_o,
  output logic [7:0]                           north_weight_o,
  output logic [7:0]                           east_weight_o,
  output logic [7:0]                           south_weight_o,
  output logic [7:0]                           west_weight_o,
  output logic [7:0]                           selected_weight_o,
  output logic signed [7:0]                    neighbor_x_o,
  output logic signed [7:0]                    neighbor_y_o,
  output logic [1:0]                           status_o,
  output logic [cgcs_pkg::CNT_W-1:0]           occupied_count_o,
  output logic [cgcs_pkg::CNT_W-1:0]           weight_count_o
);

  localparam int Cells = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (Cells > 1) ? $clog2(Cells) : 1;

  // Configuration
  logic [cgcs_pkg::CFG_DATA_W-1:0] gw_q, gh_q;

  // Item register
  cgcs_pkg::op_e      op_q;
  logic [5:0]         x_q, y_q;
  logic [2:0]         dir_q;
  logic [7:0]         pv_q, wn_q, we_q, ws_q, ww_q;
  logic [AW-1:0]      idx_q;
  logic               stored_q;

  // Memory and sweep
  cgcs_pkg::cell_word_t mem_q [Cells];
  cgcs_pkg::cell_word_t rd_q, wr_data;
  logic [AW-1:0]        sweep_q, raddr, waddr, idx_in;
  logic                 mem_we, stored_in;

  // Update
  cgcs_pkg::cell_word_t nw;
  cgcs_pkg::status_e    st;
  logic [7:0]           fin;
  logic                 occ_up, occ_dn, wc_up, wc_dn, any_w, inb;
  logic                 vis_pres, vis_w, modifies;
  logic signed [7:0]    xe, ye, nb_x, nb_y, res_nx, res_ny;
  cgcs_pkg::status_e    nb_st;
  logic [cgcs_pkg::CNT_W-1:0] occ_q, occ_d, wc_q, wc_d;
  logic [7:0]           res_pay, res_n, res_e, res_s, res_w, res_sel;

  function automatic logic [AW-1:0] cell_index(logic [5:0] px, logic [5:0] py);
    return AW'(py) * AW'(MAX_COLUMNS) + AW'(px);
  endfunction

  function automatic logic in_grid(logic signed [7:0] px, logic signed [7:0] py,
                                   logic [cgcs_pkg::CFG_DATA_W-1:0] gw,
                                   logic [cgcs_pkg::CFG_DATA_W-1:0] gh);
    return !px[7] && !py[7] && (px[6:0] < gw) && (py[6:0] < gh) &&
           (int'(px[6:0]) < MAX_COLUMNS) && (int'(py[6:0]) < MAX_ROWS);
  endfunction

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= cgcs_pkg::GRID_RESET;
      gh_q <= cgcs_pkg::GRID_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cgcs_pkg::CFG_GRID_WIDTH) gw_q <= cfg_wdata_i;
      if (cfg_idx_i == cgcs_pkg::CFG_GRID_HEIGHT) gh_q <= cfg_wdata_i;
    end
  end

  // Decode the offered beat
  assign stored_in = (int'(cell_x_i) < MAX_COLUMNS) && (int'(cell_y_i) < MAX_ROWS);
  assign idx_in    = stored_in ? cell_index(cell_x_i, cell_y_i) : '0;
  assign stat_o.in_clear_all = (operation_i == cgcs_pkg::OP_CLEAR_ALL);
  assign stat_o.sweep_last   = (sweep_q == AW'(Cells - 1));

  // Latch the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q     <= cgcs_pkg::op_e'(operation_i);
      x_q      <= cell_x_i;
      y_q      <= cell_y_i;
      dir_q    <= direction_i;
      pv_q     <= payload_value_i;
      wn_q     <= north_weight_in_i;
      we_q     <= east_weight_in_i;
      ws_q     <= south_weight_in_i;
      ww_q     <= west_weight_in_i;
      idx_q    <= idx_in;
      stored_q <= stored_in;
    end
  end

  // Sweep pointer for clearing passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.wipe) begin
      sweep_q <= stat_o.sweep_last ? '0 : sweep_q + AW'(1);
    end
  end

  // Cell memory: one write and one registered read per cycle
  assign raddr    = cmd_i.accept ? idx_in : idx_q;
  assign modifies = (op_q == cgcs_pkg::OP_CLEAR_CELL) || (op_q == cgcs_pkg::OP_SET_PAYLOAD) ||
                    (op_q == cgcs_pkg::OP_MAX_PAYLOAD) || (op_q == cgcs_pkg::OP_SET_WEIGHTS);
  assign mem_we   = cmd_i.wipe || (cmd_i.commit && stored_q && modifies);
  assign waddr    = cmd_i.wipe ? sweep_q : idx_q;
  assign wr_data  = cmd_i.wipe ? '0 : nw;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[waddr] <= wr_data;
    rd_q <= mem_q[raddr];
  end

  // Neighbor step and its bounds check
  assign xe = $signed({2'b00, x_q});
  assign ye = $signed({2'b00, y_q});

  always_comb begin
    nb_x  = xe;
    nb_y  = ye;
    nb_st = cgcs_pkg::STAT_OK;
    case (dir_q)
      cgcs_pkg::DIR_EAST:  nb_x = xe + 8'sd1;
      cgcs_pkg::DIR_NORTH: nb_y = ye + 8'sd1;
      cgcs_pkg::DIR_WEST:  nb_x = xe - 8'sd1;
      cgcs_pkg::DIR_SOUTH: nb_y = ye - 8'sd1;
      default: begin
        nb_x  = '0;
        nb_y  = '0;
        nb_st = cgcs_pkg::STAT_BAD_DIR;
      end
    endcase
    if ((nb_st == cgcs_pkg::STAT_OK) && !in_grid(nb_x, nb_y, gw_q, gh_q)) begin
      nb_st = cgcs_pkg::STAT_OOB;
    end
  end

  assign inb   = in_grid(xe, ye, gw_q, gh_q);
  assign any_w = (wn_q != cgcs_pkg::NO_INFO) || (we_q != cgcs_pkg::NO_INFO) ||
                 (ws_q != cgcs_pkg::NO_INFO) || (ww_q != cgcs_pkg::NO_INFO);

  // Modify the cell word
  always_comb begin
    nw     = rd_q;
    st     = cgcs_pkg::STAT_OK;
    fin    = pv_q;
    occ_up = 1'b0;
    occ_dn = 1'b0;
    wc_up  = 1'b0;
    wc_dn  = 1'b0;
    res_nx = '0;
    res_ny = '0;
    case (op_q)
      cgcs_pkg::OP_CLEAR_ALL: begin
        nw.present     = 1'b0;
        nw.has_weights = 1'b0;
      end
      cgcs_pkg::OP_CLEAR_CELL: begin
        if (!stored_q) begin
          st = cgcs_pkg::STAT_OOB;
        end else if (rd_q.present) begin
          nw.present     = 1'b0;
          nw.has_weights = 1'b0;
          occ_dn         = 1'b1;
          wc_dn          = rd_q.has_weights;
        end
      end
      cgcs_pkg::OP_SET_PAYLOAD, cgcs_pkg::OP_MAX_PAYLOAD: begin
        if (!inb) begin
          st = cgcs_pkg::STAT_OOB;
        end else if (rd_q.present) begin
          if ((op_q == cgcs_pkg::OP_MAX_PAYLOAD) && (rd_q.payload > pv_q)) fin = rd_q.payload;
          nw.payload = fin;
          // drop a cell that carries no information at all
          if ((fin == cgcs_pkg::NO_INFO) && !rd_q.has_weights) begin
            nw.present = 1'b0;
            occ_dn     = 1'b1;
          end
        end else if (pv_q != cgcs_pkg::NO_INFO) begin
          nw.present     = 1'b1;
          nw.payload     = pv_q;
          nw.has_weights = 1'b0;
          occ_up         = 1'b1;
        end
      end
      cgcs_pkg::OP_SET_WEIGHTS: begin
        if (!stored_q) begin
          st = cgcs_pkg::STAT_OOB;
        end else if (any_w) begin
          if (!rd_q.present) begin
            nw.present = 1'b1;
            nw.payload = '0;
            occ_up     = 1'b1;
          end
          wc_up          = !rd_q.present || !rd_q.has_weights;
          nw.has_weights = 1'b1;
          nw.north       = wn_q;
          nw.east        = we_q;
          nw.south       = ws_q;
          nw.west        = ww_q;
        end else if (rd_q.present && rd_q.has_weights) begin
          // all weights at no-information removes them
          nw.has_weights = 1'b0;
          wc_dn          = 1'b1;
        end
      end
      cgcs_pkg::OP_NEIGHBOR: begin
        st     = nb_st;
        res_nx = nb_x;
        res_ny = nb_y;
      end
      default: begin
        if (!stored_q) st = cgcs_pkg::STAT_OOB;
      end
    endcase
  end

  // Counts after the operation
  always_comb begin
    if (op_q == cgcs_pkg::OP_CLEAR_ALL) begin
      occ_d = '0;
      wc_d  = '0;
    end else begin
      occ_d = occ_q + cgcs_pkg::CNT_W'(occ_up) - cgcs_pkg::CNT_W'(occ_dn);
      wc_d  = wc_q + cgcs_pkg::CNT_W'(wc_up) - cgcs_pkg::CNT_W'(wc_dn);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      wc_q  <= '0;
    end else if (cmd_i.commit) begin
      occ_q <= occ_d;
      wc_q  <= wc_d;
    end
  end

  // View of the cell after the operation
  assign vis_pres = stored_q && nw.present;
  assign vis_w    = vis_pres && nw.has_weights;
  assign res_pay  = vis_pres ? nw.payload : cgcs_pkg::NO_INFO;
  assign res_n    = vis_w ? nw.north : cgcs_pkg::NO_INFO;
  assign res_e    = vis_w ? nw.east  : cgcs_pkg::NO_INFO;
  assign res_s    = vis_w ? nw.south : cgcs_pkg::NO_INFO;
  assign res_w    = vis_w ? nw.west  : cgcs_pkg::NO_INFO;

  always_comb begin
    case (dir_q)
      cgcs_pkg::DIR_EAST:  res_sel = res_e;
      cgcs_pkg::DIR_NORTH: res_sel = res_n;
      cgcs_pkg::DIR_WEST:  res_sel = res_w;
      cgcs_pkg::DIR_SOUTH: res_sel = res_s;
      default:             res_sel = cgcs_pkg::NO_INFO;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      payload_out_o     <= res_pay;
      north_weight_o    <= res_n;
      east_weight_o     <= res_e;
      south_weight_o    <= res_s;
      west_weight_o     <= res_w;
      selected_weight_o <= res_sel;
      neighbor_x_o      <= res_nx;
      neighbor_y_o      <= res_ny;
      status_o          <= st;
      occupied_count_o  <= occ_d;
      weight_count_o    <= wc_d;
    end
  end

  `ASSERT_STD(a_clear_zeroes_counts, cmd_i.commit && (op_q == cgcs_pkg::OP_CLEAR_ALL) |=> (occ_q == '0) && (wc_q == '0), "clear all left nonzero counts")
  `ASSERT_STD(a_sweep_advances, cmd_i.wipe && !stat_o.sweep_last |=> (sweep_q == $past(sweep_q) + AW'(1)), "sweep pointer skipped a cell")

endmodule

`default_nettype wire

>>> hw/rtl/cost_grid_cell_store_top.sv
// Cost grid cell store: a dense cell memory with present and weight marks,
// payload and four directional weights per cell, plus running counts of
// present and weighted cells. After reset the block runs a clearing pass over
// all MAX_COLUMNS*MAX_ROWS cells (4096 by default) before it takes the first
// item; configuration writes are taken throughout. Each ordinary item is
// split into accepting it and reading its cell word, then writing the word
// back, updating the counts and loading the result register, so the single
// memory port pair sets the rate; the write-back waits while a result is held.
// A clear-all walks the memory one cell a cycle, then loads its result. A new item
// is accepted while the previous result still waits in the output register.
// Depends on cgcs_pkg, cgcs_item_if, cgcs_result_if, cgcs_ctrl, cgcs_datapath.
`default_nettype none

module cost_grid_cell_store_top #(
  parameter int MAX_COLUMNS = cgcs_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cgcs_pkg::MAX_ROWS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cgcs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cgcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  cgcs_item_if.sink                            item_if,
  cgcs_result_if.source                        result_if
);

  cgcs_pkg::ctrl_cmd_t  cmd;
  cgcs_pkg::dp_status_t dp_stat;

  cgcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_if.valid),
    .item_ready_o (item_if.ready),
    .out_valid_o  (result_if.valid),
    .out_ready_i  (result_if.ready),
    .cmd_o        (cmd),
    .stat_i       (dp_stat)
  );

  cgcs_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .operation_i       (item_if.operation),
    .cell_x_i          (item_if.cell_x),
    .cell_y_i          (item_if.cell_y),
    .direction_i       (item_if.direction),
    .payload_value_i   (item_if.payload_value),
    .north_weight_in_i (item_if.north_weight_in),
    .east_weight_in_i  (item_if.east_weight_in),
    .south_weight_in_i (item_if.south_weight_in),
    .west_weight_in_i  (item_if.west_weight_in),
    .cmd_i             (cmd),
    .stat_o            (dp_stat),
    .payload_out_o     (result_if.payload_out),
    .north_weight_o    (result_if.north_weight),
    .east_weight_o     (result_if.east_weight),
    .south_weight_o    (result_if.south_weight),
    .west_weight_o     (result_if.west_weight),
    .selected_weight_o (result_if.selected_weight),
    .neighbor_x_o      (result_if.neighbor_x),
    .neighbor_y_o      (result_if.neighbor_y),
    .status_o          (result_if.status),
    .occupied_count_o  (result_if.occupied_count),
    .weight_count_o    (result_if.weight_count)
  );

endmodule

`default_nettype wire
